[rtl/gbhs_pkg.sv]
// Package for the grid bilinear height and slope block.
// Holds grid constants, status and register codes, controller and datapath types.
// Depends on nothing.
`default_nettype none
package gbhs_pkg;

    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int GRID_DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_BITS   = $clog2(GRID_DEPTH);
    localparam int HEIGHT_BITS = 32;
    localparam int DIM_BITS    = 9;
    localparam int CFG_IDX_BITS = 3;
    // Cell offset from the lower-left center, 16 fraction bits, range -1/2 .. 1.
    localparam int OFF_BITS    = 18;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NODATA  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_WRITE   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_CELL  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_DATA   = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_WRITE, S_MUL_X, S_AXIS_X, S_AXIS_Y,
        S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_CHECK,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10, S_M11,
        S_PUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_WRITE, OP_MUL_X, OP_AXIS_X, OP_AXIS_Y,
        OP_RD0, OP_RD1, OP_RD2, OP_RD3, OP_RD4, OP_CHECK,
        OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9, OP_M10, OP_M11,
        OP_PUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic outside;
        logic no_data;
        logic out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

[rtl/gbhs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module gbhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/gbhs_ctrl.sv]
// Sequencer for the grid bilinear height and slope block.
// Depends on gbhs_pkg; drives the datapath by one command per cycle.
`default_nettype none
module gbhs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_operation,
    output logic                    o_ready,
    input  wire gbhs_pkg::t_dp_stat i_stat,
    output gbhs_pkg::t_dp_cmd       o_cmd
);
    import gbhs_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_ready      = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_operation ? S_WRITE : S_MUL_X;
                end
            end
            S_WRITE: begin
                o_cmd.op = OP_WRITE;
                n_status = ST_WRITE;
                n_state  = S_PUT;
            end
            S_MUL_X:  begin o_cmd.op = OP_MUL_X;  n_state = S_AXIS_X; end
            S_AXIS_X: begin o_cmd.op = OP_AXIS_X; n_state = S_AXIS_Y; end
            S_AXIS_Y: begin o_cmd.op = OP_AXIS_Y; n_state = S_RD0;    end
            S_RD0: begin
                o_cmd.op = OP_RD0;
                if (i_stat.outside) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_PUT;
                end else begin
                    n_state = S_RD1;
                end
            end
            S_RD1:   begin o_cmd.op = OP_RD1;   n_state = S_RD2;   end
            S_RD2:   begin o_cmd.op = OP_RD2;   n_state = S_RD3;   end
            S_RD3:   begin o_cmd.op = OP_RD3;   n_state = S_RD4;   end
            S_RD4:   begin o_cmd.op = OP_RD4;   n_state = S_CHECK; end
            S_CHECK: begin o_cmd.op = OP_CHECK; n_state = S_M1;    end
            S_M1: begin
                o_cmd.op = OP_M1;
                if (i_stat.no_data) begin
                    n_status = ST_NODATA;
                    n_state  = S_PUT;
                end else begin
                    n_state = S_M2;
                end
            end
            S_M2:  begin o_cmd.op = OP_M2;  n_state = S_M3;  end
            S_M3:  begin o_cmd.op = OP_M3;  n_state = S_M4;  end
            S_M4:  begin o_cmd.op = OP_M4;  n_state = S_M5;  end
            S_M5:  begin o_cmd.op = OP_M5;  n_state = S_M6;  end
            S_M6:  begin o_cmd.op = OP_M6;  n_state = S_M7;  end
            S_M7:  begin o_cmd.op = OP_M7;  n_state = S_M8;  end
            S_M8:  begin o_cmd.op = OP_M8;  n_state = S_M9;  end
            S_M9:  begin o_cmd.op = OP_M9;  n_state = S_M10; end
            S_M10: begin o_cmd.op = OP_M10; n_state = S_M11; end
            S_M11: begin
                o_cmd.op = OP_M11;
                n_status = ST_OK;
                n_state  = S_PUT;
            end
            S_PUT: begin
                // Wait here until the output register is free.
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_PUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/gbhs_dp.sv]
// Datapath of the grid bilinear height and slope block: configuration registers,
// one shared multiplier, the height grid memory and the output register.
// Depends on gbhs_pkg and gbhs_ram.
`default_nettype none
module gbhs_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire gbhs_pkg::t_dp_cmd                    i_cmd,
    output gbhs_pkg::t_dp_stat                        o_stat,
    input  wire logic signed [31:0]                   i_point_x,
    input  wire logic signed [31:0]                   i_point_y,
    input  wire logic [7:0]                           i_cell_col,
    input  wire logic [7:0]                           i_cell_row,
    input  wire logic signed [31:0]                   i_cell_height,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [gbhs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [31:0]                          i_cfg_data,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [1:0]                                o_status,
    output logic signed [31:0]                        o_height,
    output logic signed [31:0]                        o_slope_x,
    output logic signed [31:0]                        o_slope_y
);
    import gbhs_pkg::*;

    // Configuration.
    logic signed [31:0]  r_org_x, r_org_y, r_nd;
    logic [31:0]         r_inv;
    logic [DIM_BITS-1:0] r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_inv   <= 32'd65536;
            r_cols  <= 9'd256;
            r_rows  <= 9'd256;
            r_nd    <= -32'sd655294464;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:  r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y:  r_org_y <= i_cfg_data;
                CFG_INV_CELL:  r_inv   <= i_cfg_data;
                CFG_GRID_COLS: r_cols  <= i_cfg_data[DIM_BITS-1:0];
                CFG_GRID_ROWS: r_rows  <= i_cfg_data[DIM_BITS-1:0];
                CFG_NO_DATA:   r_nd    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [ADDR_BITS-1:0] grid_addr(input logic [ROW_BITS-1:0] row,
                                                       input logic [COL_BITS-1:0] col);
        grid_addr = ADDR_BITS'(row) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(col);
    endfunction

    // Final step of a slope: negate and saturate a rounded magnitude.
    function automatic logic [31:0] slope_fin(input logic [54:0] r, input logic neg);
        if (neg) begin
            slope_fin = (r > 55'd2147483647) ? 32'h7FFF_FFFF : r[31:0];
        end else begin
            slope_fin = (r > 55'd2147483648) ? 32'h8000_0000 : (~r[31:0] + 32'd1);
        end
    endfunction

    // Working registers.
    logic signed [32:0]          r_dx, r_dy;
    logic [7:0]                  r_wr_col, r_wr_row;
    logic [31:0]                 r_wr_h;
    logic signed [66:0]          r_prod;
    logic [COL_BITS-1:0]         r_xl, r_xh;
    logic [ROW_BITS-1:0]         r_yl, r_yh;
    logic signed [OFF_BITS-1:0]  r_xp, r_yp, r_pxy;
    logic                        r_outside, r_no_data;
    logic signed [31:0]          r_z00, r_z10, r_z01, r_z11;
    logic signed [32:0]          r_a, r_b;
    logic signed [33:0]          r_g;
    logic signed [55:0]          r_acc;
    logic signed [53:0]          r_numx, r_numy;
    logic [52:0]                 r_magx, r_magy;
    logic                        r_negx, r_negy;
    logic [32:0]                 r_lo;
    logic [31:0]                 r_height, r_sx, r_sy;
    logic                        r_o_valid;
    logic [1:0]                  r_o_status;
    logic [31:0]                 r_o_height, r_o_sx, r_o_sy;

    // Shared multiplier operands.
    logic signed [33:0] m_a;
    logic signed [32:0] m_b;
    logic signed [66:0] w_prod;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_MUL_X:  begin m_a = {r_dx[32], r_dx}; m_b = {1'b0, r_inv}; end
            OP_AXIS_X: begin m_a = {r_dy[32], r_dy}; m_b = {1'b0, r_inv}; end
            OP_RD0: begin
                m_a = {{(34-OFF_BITS){r_xp[OFF_BITS-1]}}, r_xp};
                m_b = {{(33-OFF_BITS){r_yp[OFF_BITS-1]}}, r_yp};
            end
            OP_M1: begin m_a = {r_a[32], r_a}; m_b = {{(33-OFF_BITS){r_xp[OFF_BITS-1]}}, r_xp}; end
            OP_M2: begin m_a = {r_b[32], r_b}; m_b = {{(33-OFF_BITS){r_yp[OFF_BITS-1]}}, r_yp}; end
            OP_M3: begin m_a = r_g; m_b = {{(33-OFF_BITS){r_pxy[OFF_BITS-1]}}, r_pxy}; end
            OP_M4: begin m_a = r_g; m_b = {{(33-OFF_BITS){r_yp[OFF_BITS-1]}}, r_yp}; end
            OP_M5: begin m_a = r_g; m_b = {{(33-OFF_BITS){r_xp[OFF_BITS-1]}}, r_xp}; end
            OP_M7:  begin m_a = {2'b00, r_magx[31:0]};    m_b = {1'b0, r_inv}; end
            OP_M8:  begin m_a = {13'd0, r_magx[52:32]};   m_b = {1'b0, r_inv}; end
            OP_M9:  begin m_a = {2'b00, r_magy[31:0]};    m_b = {1'b0, r_inv}; end
            OP_M10: begin m_a = {13'd0, r_magy[52:32]};   m_b = {1'b0, r_inv}; end
            default: ;
        endcase
    end

    assign w_prod = m_a * m_b;

    // Axis location from the registered scaled coordinate.
    logic [31:0]                ax_idx, ax_idx1, ax_f, ax_n, ax_lo, ax_hi;
    logic                       ax_out, ax_dneg;
    logic signed [OFF_BITS-1:0] ax_off, ax_f16;

    always_comb begin
        ax_idx  = r_prod[63:32];
        ax_f    = r_prod[31:0];
        ax_idx1 = ax_idx + 32'd1;
        ax_f16  = {2'b00, ax_f[31:16]};
        if (i_cmd.op == OP_AXIS_X) begin
            ax_dneg = r_dx[32];
            ax_n = (32'(r_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(r_cols);
        end else begin
            ax_dneg = r_dy[32];
            ax_n = (32'(r_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(r_rows);
        end
        ax_out = ax_dneg || (ax_n == 32'd0) || (ax_idx >= ax_n);
        if (ax_f > 32'h8000_0000) begin
            ax_lo  = ax_idx;
            ax_hi  = (ax_idx1 < ax_n) ? ax_idx1 : ax_idx;
            ax_off = ax_f16 - 18'sd32768;
        end else if (ax_idx != 32'd0) begin
            ax_lo  = ax_idx - 32'd1;
            ax_hi  = ax_idx;
            ax_off = ax_f16 + 18'sd32768;
        end else begin
            ax_lo  = '0;
            ax_hi  = '0;
            ax_off = ax_f16 - 18'sd32768;
        end
    end

    // Grid memory.
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [31:0]           ram_rdata;

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = grid_addr(r_yl, r_xl);
        case (i_cmd.op)
            OP_WRITE: begin
                ram_we = (32'(r_wr_col) < 32'(MAX_COLS)) && (32'(r_wr_row) < 32'(MAX_ROWS));
                ram_addr = grid_addr(ROW_BITS'(r_wr_row), COL_BITS'(r_wr_col));
            end
            OP_RD1:  ram_addr = grid_addr(r_yl, r_xh);
            OP_RD2:  ram_addr = grid_addr(r_yh, r_xl);
            OP_RD3:  ram_addr = grid_addr(r_yh, r_xh);
            default: ;
        endcase
    end

    gbhs_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_wr_h),
        .o_rdata (ram_rdata)
    );

    // Arithmetic helpers.
    logic signed [39:0] w_pxy_t;
    logic signed [55:0] w_acc_sum, w_h_t;
    logic signed [39:0] w_h_sh;
    logic signed [53:0] w_num;
    logic [64:0]        w_lo_t;
    logic [54:0]        w_r;

    assign w_pxy_t   = $signed(r_prod[39:0]) + 40'sd32768;
    assign w_acc_sum = r_acc + $signed(r_prod[55:0]);
    assign w_h_t     = r_acc + 56'sd32768;
    assign w_h_sh    = w_h_t[55:16];
    assign w_num     = (i_cmd.op == OP_M5) ? ({{5{r_a[32]}}, r_a, 16'd0} + $signed(r_prod[53:0]))
                                           : ({{5{r_b[32]}}, r_b, 16'd0} + $signed(r_prod[53:0]));
    assign w_lo_t    = {1'b0, r_prod[63:0]} + 65'h0_8000_0000;
    assign w_r       = r_prod[54:0] + {22'd0, r_lo};

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            OP_LOAD: begin
                r_dx     <= {i_point_x[31], i_point_x} - {r_org_x[31], r_org_x};
                r_dy     <= {i_point_y[31], i_point_y} - {r_org_y[31], r_org_y};
                r_wr_col <= i_cell_col;
                r_wr_row <= i_cell_row;
                r_wr_h   <= i_cell_height;
            end
            OP_AXIS_X: begin
                r_xl      <= COL_BITS'(ax_lo);
                r_xh      <= COL_BITS'(ax_hi);
                r_xp      <= ax_off;
                r_outside <= ax_out;
            end
            OP_AXIS_Y: begin
                r_yl      <= ROW_BITS'(ax_lo);
                r_yh      <= ROW_BITS'(ax_hi);
                r_yp      <= ax_off;
                r_outside <= r_outside | ax_out;
            end
            OP_RD1: begin
                r_z00 <= ram_rdata;
                r_pxy <= w_pxy_t[33:16];
            end
            OP_RD2: r_z10 <= ram_rdata;
            OP_RD3: r_z01 <= ram_rdata;
            OP_RD4: r_z11 <= ram_rdata;
            OP_CHECK: begin
                r_a <= {r_z10[31], r_z10} - {r_z00[31], r_z00};
                r_b <= {r_z01[31], r_z01} - {r_z00[31], r_z00};
                r_g <= {{2{r_z11[31]}}, r_z11} + {{2{r_z00[31]}}, r_z00}
                     - {{2{r_z10[31]}}, r_z10} - {{2{r_z01[31]}}, r_z01};
                r_no_data <= (r_z00 == r_nd) || (r_z10 == r_nd) ||
                             (r_z01 == r_nd) || (r_z11 == r_nd);
            end
            OP_M1: r_acc <= {{8{r_z00[31]}}, r_z00, 16'd0};
            OP_M2, OP_M3, OP_M4: r_acc <= w_acc_sum;
            OP_M5: begin
                if (w_h_sh > 40'sd2147483647) begin
                    r_height <= 32'h7FFF_FFFF;
                end else if (w_h_sh < -40'sd2147483648) begin
                    r_height <= 32'h8000_0000;
                end else begin
                    r_height <= w_h_sh[31:0];
                end
                r_numx <= w_num;
            end
            OP_M6: begin
                r_numy <= w_num;
                r_negx <= r_numx[53];
                r_magx <= r_numx[53] ? 53'(-r_numx) : r_numx[52:0];
            end
            OP_M7: begin
                r_negy <= r_numy[53];
                r_magy <= r_numy[53] ? 53'(-r_numy) : r_numy[52:0];
            end
            OP_M8, OP_M10: r_lo <= w_lo_t[64:32];
            OP_M9:  r_sx <= slope_fin(w_r, r_negx);
            OP_M11: r_sy <= slope_fin(w_r, r_negy);
            default: ;
        endcase
    end

    // Output register: the next item may be taken while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.op == OP_PUT) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PUT) begin
            r_o_status <= i_cmd.status;
            case (i_cmd.status)
                ST_OK: begin
                    r_o_height <= r_height;
                    r_o_sx     <= r_sx;
                    r_o_sy     <= r_sy;
                end
                ST_NODATA: begin
                    r_o_height <= r_nd;
                    r_o_sx     <= r_nd;
                    r_o_sy     <= r_nd;
                end
                default: begin
                    r_o_height <= '0;
                    r_o_sx     <= '0;
                    r_o_sy     <= '0;
                end
            endcase
        end
    end

    assign o_stat.outside  = r_outside;
    assign o_stat.no_data  = r_no_data;
    assign o_stat.out_busy = r_o_valid && !i_ready;

    assign o_valid   = r_o_valid;
    assign o_status  = r_o_status;
    assign o_height  = r_o_height;
    assign o_slope_x = r_o_sx;
    assign o_slope_y = r_o_sy;
endmodule
`default_nettype wire

[rtl/grid_bilinear_height_slope.sv]
// Grid bilinear height and slope: one item at a time through a shared multiplier
// and a single-port grid memory. A point outside the grid ends at the first read
// step, a no-data query after the corner check. The block is ready again once the
// result is loaded, which waits for a free output register. Reset is synchronous,
// active low; it restores the register defaults and leaves the grid memory
// undefined until written.
`default_nettype none
module grid_bilinear_height_slope (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_operation,
    input  wire logic signed [31:0]                i_point_x,
    input  wire logic signed [31:0]                i_point_y,
    input  wire logic [7:0]                        i_cell_col,
    input  wire logic [7:0]                        i_cell_row,
    input  wire logic signed [31:0]                i_cell_height,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [1:0]                             o_status,
    output logic signed [31:0]                     o_height,
    output logic signed [31:0]                     o_slope_x,
    output logic signed [31:0]                     o_slope_y,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gbhs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data
);
    import gbhs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    gbhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gbhs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_cell_col    (i_cell_col),
        .i_cell_row    (i_cell_row),
        .i_cell_height (i_cell_height),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_height      (o_height),
        .o_slope_x     (o_slope_x),
        .o_slope_y     (o_slope_y)
    );

    // One item at a time: after a transfer in, the input side closes.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while an item is at work");

    a_nodata_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NODATA) |->
            (o_height == o_slope_x && o_slope_x == o_slope_y))
        else $error("no-data result fields differ");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OUTSIDE || o_status == ST_WRITE)) |->
            (o_height == 32'sd0 && o_slope_x == 32'sd0 && o_slope_y == 32'sd0))
        else $error("outside or write result carries nonzero fields");
endmodule
`default_nettype wire

[tb/grid_bilinear_height_slope_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the grid bilinear height and slope block.
// Predicts results from its copy of grid and registers, unless given; depends on gbhs_pkg.
module grid_bilinear_height_slope_tb;
    import gbhs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 25;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] height;
        logic [31:0] slope_x;
        logic [31:0] slope_y;
    } t_lookup;

    typedef struct {
        logic        op;
        logic [31:0] px;
        logic [31:0] py;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] hgt;
        bit          typed;
        t_lookup     want;
    } t_vector;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_operation = 0;
    logic [31:0] i_point_x = 0;
    logic [31:0] i_point_y = 0;
    logic [7:0]  i_cell_col = 0;
    logic [7:0]  i_cell_row = 0;
    logic [31:0] i_cell_height = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic [31:0] o_height;
    logic [31:0] o_slope_x;
    logic [31:0] o_slope_y;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_ORIGIN_X;
    logic [31:0] i_cfg_data = 0;

    grid_bilinear_height_slope uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's grid and registers.
    logic [31:0] grid_copy [GRID_DEPTH];
    bit          written   [GRID_DEPTH];
    logic signed [31:0] org_x, org_y, nodata;
    logic [31:0] inv_size;
    logic [8:0]  cols_reg, rows_reg;

    t_lookup pending_lookups[$];
    t_vector directed[$];
    int      errors = 0;
    int      stalled_cycles = 0;
    bit      quiet = 0;
    bit      hold_req = 0;

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    function automatic bit locate_axis(logic [31:0] p, logic signed [31:0] org, int n,
                                       output int lo, output int hi, output longint off);
        longint     d;
        bit [63:0]  u;
        bit [63:0]  idx;
        bit [31:0]  frac;
        longint     f16;
        lo = 0; hi = 0; off = 0;
        d = longint'(signed'(p)) - longint'(org);
        if (d < 0 || n == 0) return 0;
        u = 64'(d) * 64'(inv_size);
        idx = u >> 32;
        if (idx >= 64'(n)) return 0;
        frac = u[31:0];
        f16 = longint'(frac >> 16);
        if (frac > 32'h8000_0000) begin
            lo = int'(idx);
            hi = (int'(idx) + 1 < n) ? int'(idx) + 1 : n - 1;
            off = f16 - 32768;
        end else if (idx > 0) begin
            lo = int'(idx) - 1;
            hi = int'(idx);
            off = f16 + 32768;
        end else begin
            off = f16 - 32768;
        end
        return 1;
    endfunction

    function automatic int eff_cols();
        return cols_reg > MAX_COLS ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic int eff_rows();
        return rows_reg > MAX_ROWS ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic longint height_at(int c, int r);
        return longint'(signed'(grid_copy[r * MAX_COLS + c]));
    endfunction

    // Negated gradient times inverse cell size, rounded half away from zero and saturated.
    function automatic logic [31:0] scaled_slope(longint g);
        bit        neg;
        bit [63:0] m, hi_p, lo_p, r;
        neg = g < 0;
        m = neg ? 64'(-g) : 64'(g);
        hi_p = (m >> 32) * 64'(inv_size);
        lo_p = 64'(m[31:0]) * 64'(inv_size);
        r = hi_p + ((lo_p + 64'h8000_0000) >> 32);
        if (neg) return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
        return r > 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(r));
    endfunction

    function automatic logic [31:0] sat_height(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // True when a query at this point reads only cells that hold a written height.
    function automatic bit reads_written(logic [31:0] px, logic [31:0] py);
        int xl, xh, yl, yh;
        longint xp, yp;
        if (!locate_axis(px, org_x, eff_cols(), xl, xh, xp) ||
            !locate_axis(py, org_y, eff_rows(), yl, yh, yp))
            return 1;
        return written[yl*MAX_COLS+xl] && written[yl*MAX_COLS+xh] &&
               written[yh*MAX_COLS+xl] && written[yh*MAX_COLS+xh];
    endfunction

    function automatic t_lookup predict_lookup(logic op, logic [31:0] px, logic [31:0] py,
                                               logic [7:0] col, logic [7:0] row,
                                               logic [31:0] hgt);
        t_lookup res;
        int xl, xh, yl, yh;
        longint xp, yp, z00, z10, z01, z11, a, b, g, pxy, acc;
        res = '{ST_OK, 32'h0, 32'h0, 32'h0};
        if (op) begin
            grid_copy[row * MAX_COLS + col] = hgt;
            written[row * MAX_COLS + col] = 1;
            res.status = ST_WRITE;
            return res;
        end
        if (!locate_axis(px, org_x, eff_cols(), xl, xh, xp) ||
            !locate_axis(py, org_y, eff_rows(), yl, yh, yp)) begin
            res.status = ST_OUTSIDE;
            return res;
        end
        z00 = height_at(xl, yl);
        z10 = height_at(xh, yl);
        z01 = height_at(xl, yh);
        z11 = height_at(xh, yh);
        if (z00 == nodata || z10 == nodata || z01 == nodata || z11 == nodata) begin
            res = '{ST_NODATA, nodata, nodata, nodata};
            return res;
        end
        a = z10 - z00;
        b = z01 - z00;
        g = z11 + z00 - z10 - z01;
        pxy = (xp * yp + 32768) >>> 16;
        acc = z00 * 65536 + a * xp + b * yp + g * pxy;
        res.height = sat_height((acc + 32768) >>> 16);
        res.slope_x = scaled_slope(a * 65536 + g * yp);
        res.slope_y = scaled_slope(b * 65536 + g * xp);
        return res;
    endfunction

    // Offers one transfer and holds it until accepted; valid stays high afterwards.
    task automatic send_lookup(logic op, logic [31:0] px, logic [31:0] py,
                               logic [7:0] col, logic [7:0] row, logic [31:0] hgt,
                               bit typed = 0, t_lookup want = '{0, 0, 0, 0});
        t_lookup res;
        @(negedge i_clk);
        i_valid = 1;
        i_operation = op;
        i_point_x = px;
        i_point_y = py;
        i_cell_col = col;
        i_cell_row = row;
        i_cell_height = hgt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = predict_lookup(op, px, py, col, row, hgt);
        pending_lookups.insert(pending_lookups.size(), typed ? want : res);
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        i_valid = 0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_valid = 0;
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ORIGIN_X:  org_x = data;
            CFG_ORIGIN_Y:  org_y = data;
            CFG_INV_CELL:  inv_size = data;
            CFG_GRID_COLS: cols_reg = data[8:0];
            CFG_GRID_ROWS: rows_reg = data[8:0];
            CFG_NO_DATA:   nodata = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic wait_drained();
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A point whose scaled position falls inside the given cell, with a random fraction.
    function automatic logic [31:0] point_for(int idx, logic signed [31:0] org);
        bit [63:0] c;
        if (inv_size == 0) return 32'(longint'(org) + $urandom_range(0, 65535));
        c = {32'(idx), ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom()};
        return 32'(longint'(org) + longint'(c / 64'(inv_size)));
    endfunction

    function automatic logic [31:0] random_height();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2:    return nodata;
            default: return 32'(signed'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    task automatic add_row(t_vector row);
        directed.insert(directed.size(), row);
    endtask

    task automatic load_directed();
        t_lookup none;
        none = '{ST_OK, 32'h0, 32'h0, 32'h0};
        add_row('{1, $urandom(), $urandom(), 8'd0, 8'd0, 32'h0001_0000, 1,
                  '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd1, 8'd0, 32'h0003_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd0, 8'd1, 32'h7FFF_FFFF, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd1, 8'd1, 32'h8000_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{0, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, '{ST_OUTSIDE, 0, 0, 0}});
        add_row('{0, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, '{ST_OUTSIDE, 0, 0, 0}});
        add_row('{0, 0, 32'h8000_0000, 0, 0, 0, 1, '{ST_OUTSIDE, 0, 0, 0}});
        add_row('{0, 32'h0000_4000, 32'h0000_4000, 0, 0, 0, 0, none});
        add_row('{0, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0, none});
        add_row('{0, 32'h0000_C000, 32'h0001_4000, 0, 0, 0, 0, none});
        add_row('{0, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, none});
        add_row('{1, 0, 0, 8'd255, 8'd255, 32'h0000_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd254, 8'd255, 32'h0010_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd255, 8'd254, 32'hFFF0_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd254, 8'd254, 32'h0005_0000, 1, '{ST_WRITE, 0, 0, 0}});
        // Upper grid corner: past the last center an axis clamps, so its gradient is zero.
        add_row('{0, 32'h00FF_E000, 32'h00FF_E000, 0, 0, 0, 0, none});
        add_row('{0, 32'h00FE_A000, 32'h00FF_F000, 0, 0, 0, 0, none});
        add_row('{0, 32'h0100_0000, 32'h00FF_0000, 0, 0, 0, 0, none});
        add_row('{1, 0, 0, 8'd2, 8'd0, 32'hD8F1_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{1, 0, 0, 8'd2, 8'd1, 32'h0002_0000, 1, '{ST_WRITE, 0, 0, 0}});
        add_row('{0, 32'h0001_A000, 32'h0000_3000, 0, 0, 0, 1,
                  '{ST_NODATA, 32'hD8F1_0000, 32'hD8F1_0000, 32'hD8F1_0000}});
    endtask

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
                i_ready = 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_ready = 0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_lookups.size() == 0) begin
                $display("unexpected result transfer at %0t", $realtime);
                errors++;
            end else begin
                want = pending_lookups.pop_front();
                if (o_status !== want.status) report_mismatch("status", want.status, o_status);
                if (o_height !== want.height) report_mismatch("height", want.height, o_height);
                if (o_slope_x !== want.slope_x)
                    report_mismatch("slope_x", want.slope_x, o_slope_x);
                if (o_slope_y !== want.slope_y)
                    report_mismatch("slope_y", want.slope_y, o_slope_y);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int ph, k, n, cx, cy, bx, by, bw, bh, ec, er;
        logic [31:0] px, py;
        logic [31:0] inv_choices[7];
        inv_choices = '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_0001,
                        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000};
        org_x = 0; org_y = 0; inv_size = 32'h0001_0000;
        cols_reg = 9'd256; rows_reg = 9'd256; nodata = 32'hD8F1_0000;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        load_directed();
        foreach (directed[i])
            send_lookup(directed[i].op, directed[i].px, directed[i].py, directed[i].col,
                        directed[i].row, directed[i].hgt, directed[i].typed,
                        directed[i].want);

        for (ph = 0; ph < 14; ph++) begin
            pause_sender(1);
            wait_drained();
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_GRID_COLS, 8);
                    write_reg(CFG_GRID_ROWS, 8);
                end
                2: begin
                    write_reg(CFG_ORIGIN_X, 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000);
                    write_reg(CFG_ORIGIN_Y, 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000);
                    write_reg(CFG_INV_CELL, 32'h0000_8000);
                    write_reg(CFG_GRID_COLS, $urandom_range(1, 16));
                    write_reg(CFG_GRID_ROWS, $urandom_range(1, 16));
                end
                3: begin
                    write_reg(CFG_INV_CELL, 32'h0002_0000);
                    write_reg(CFG_GRID_COLS, 1);
                    write_reg(CFG_GRID_ROWS, 1);
                end
                4: begin
                    write_reg(CFG_INV_CELL, 32'h0);
                    write_reg(CFG_GRID_COLS, 3);
                    write_reg(CFG_GRID_ROWS, 5);
                end
                5: begin
                    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
                    write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
                    write_reg(CFG_INV_CELL, 32'hFFFF_FFFF);
                    write_reg(CFG_GRID_COLS, 256);
                    write_reg(CFG_GRID_ROWS, 256);
                    hold_req = 1;
                end
                6: begin
                    write_reg(CFG_ORIGIN_X, 0);
                    write_reg(CFG_ORIGIN_Y, 0);
                    write_reg(CFG_INV_CELL, 32'h0001_0000);
                    write_reg(CFG_GRID_COLS, 0);
                    write_reg(CFG_GRID_ROWS, 7);
                end
                7: begin
                    write_reg(CFG_GRID_COLS, 32'hFFFF_FFFF);
                    write_reg(CFG_GRID_ROWS, 300);
                    write_reg(CFG_NO_DATA, 32'h8000_0000);
                end
                8: begin
                    write_reg(CFG_ORIGIN_X, 32'h7FFF_0000);
                    write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
                    write_reg(CFG_GRID_COLS, 2);
                    write_reg(CFG_GRID_ROWS, 2);
                    write_reg(CFG_NO_DATA, 32'h7FFF_FFFF);
                end
                default: begin
                    write_reg(CFG_ORIGIN_X, $urandom_range(0, 1) ? $urandom()
                              : 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000);
                    write_reg(CFG_ORIGIN_Y, $urandom_range(0, 1) ? $urandom()
                              : 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000);
                    write_reg(CFG_INV_CELL, $urandom_range(0, 3) == 0 ? $urandom()
                              : inv_choices[$urandom_range(0, 6)]);
                    write_reg(CFG_GRID_COLS, $urandom_range(0, 2) == 0 ? $urandom()
                              : $urandom_range(1, 12));
                    write_reg(CFG_GRID_ROWS, $urandom_range(0, 2) == 0 ? $urandom()
                              : $urandom_range(1, 12));
                    write_reg(CFG_NO_DATA, $urandom());
                end
            endcase
            quiet = (ph == 13);
            ec = eff_cols();
            er = eff_rows();
            bw = ec < 4 ? ec : 4;
            bh = er < 4 ? er : 4;
            bx = ec > 4 ? $urandom_range(0, ec - 4) : 0;
            by = er > 4 ? $urandom_range(0, er - 4) : 0;
            // Fill the working block with a one-cell margin so every neighbourhood is known.
            if (ec > 0 && er > 0) begin
                for (cy = (by > 0 ? by - 1 : 0); cy <= by + bh && cy < er; cy++)
                    for (cx = (bx > 0 ? bx - 1 : 0); cx <= bx + bw && cx < ec; cx++)
                        send_lookup(1, $urandom(), $urandom(), cx, cy, random_height());
            end
            n = (ec == 0 || er == 0) ? 40 : 85;
            for (k = 0; k < n; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        if (ec == 0 || er == 0) begin
                            px = $urandom();
                            py = $urandom();
                        end else begin
                            px = point_for(bx + $urandom_range(0, bw - 1), org_x);
                            py = point_for(by + $urandom_range(0, bh - 1), org_y);
                        end
                        if (reads_written(px, py))
                            send_lookup(0, px, py, $urandom(), $urandom(), $urandom());
                    end
                    6: begin
                        px = $urandom();
                        py = $urandom();
                        if (reads_written(px, py))
                            send_lookup(0, px, py, $urandom(), $urandom(), $urandom());
                    end
                    default: begin
                        if ($urandom_range(0, 1) && ec > 0 && er > 0)
                            send_lookup(1, $urandom(), $urandom(),
                                        bx + $urandom_range(0, bw - 1),
                                        by + $urandom_range(0, bh - 1), random_height());
                        else
                            send_lookup(1, $urandom(), $urandom(), $urandom(), $urandom(),
                                        random_height());
                    end
                endcase
                if (!quiet && $urandom_range(0, 7) == 0)
                    pause_sender($urandom_range(1, 8));
            end
        end
        pause_sender(1);
        wait_drained();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[grid_bilinear_height_slope.f]
rtl/gbhs_pkg.sv
rtl/gbhs_ram.sv
rtl/gbhs_ctrl.sv
rtl/gbhs_dp.sv
rtl/grid_bilinear_height_slope.sv
tb/grid_bilinear_height_slope_tb.sv
